// File: rtl/assert_macros.svh
// assertion macros for the led pattern generator rtl
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BLPG_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");

`define BLPG_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("forbidden condition seen");

`else

`define BLPG_ASSERT(lbl, clk_s, rstn_s, prop)

`define BLPG_NEVER(lbl, clk_s, rstn_s, cond)

`endif

`endif

// File: rtl/blpg_pkg.sv
// shared types, codes and constants for the bicolor led pattern generator
// no dependencies
package blpg_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int CFG_DW       = 16;
  localparam int CFG_AW       = 3;
  localparam int MODE_W       = 4;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [CFG_DW-1:0]       cfg_word_t;

  typedef enum logic [0:0] {
    OP_TICK    = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF          = 4'd0,
    MODE_GREEN        = 4'd1,
    MODE_RED          = 4'd2,
    MODE_SLOW_BLINK_G = 4'd3,
    MODE_SLOW_BLINK_R = 4'd4,
    MODE_FAST_BLINK_G = 4'd5,
    MODE_FAST_BLINK_R = 4'd6,
    MODE_FAST_STRB_G  = 4'd7,
    MODE_FAST_STRB_R  = 4'd8,
    MODE_SLOW_STRB_G  = 4'd9,
    MODE_SLOW_STRB_R  = 4'd10
  } mode_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_SLOW_BLINK   = 3'd0,
    REG_FAST_BLINK   = 3'd1,
    REG_FAST_PERIOD  = 3'd2,
    REG_FAST_WINDOW  = 3'd3,
    REG_SLOW_PERIOD  = 3'd4,
    REG_SLOW_WINDOW  = 3'd5
  } reg_idx_t;

  localparam cfg_word_t RST_SLOW_BLINK  = 16'd35;
  localparam cfg_word_t RST_FAST_BLINK  = 16'd5;
  localparam cfg_word_t RST_FAST_PERIOD = 16'd100;
  localparam cfg_word_t RST_FAST_WINDOW = 16'd25;
  localparam cfg_word_t RST_SLOW_PERIOD = 16'd50;
  localparam cfg_word_t RST_SLOW_WINDOW = 16'd10;

  typedef struct packed {
    op_t               op;
    logic [MODE_W-1:0] mode;
  } item_t;

  typedef struct packed {
    logic red;
    logic green;
  } lvl_t;

  // config values already fitted to the counter width
  typedef struct packed {
    cnt_t slow_blink;
    cnt_t fast_blink;
    cnt_t fast_period;
    cnt_t fast_window;
    cnt_t slow_period;
    cnt_t slow_window;
  } cfg_t;

  // zero-extend or truncate a register value to the counter width
  function automatic cnt_t to_cnt(input cfg_word_t w);
    logic [COUNTER_BITS+CFG_DW-1:0] ext;
    ext = {{COUNTER_BITS{1'b0}}, w};
    return ext[COUNTER_BITS-1:0];
  endfunction

endpackage

// File: rtl/bicolor_led_pattern_generator_unit.sv
// Bicolor LED pattern generator. Each input item is a tick (in_tuser 0), which
// counts the blink and strobe counters down, or a refresh (in_tuser 1), which
// applies the mode in in_tdata and updates the green/red levels; every item
// gives exactly one result with both levels. One item is taken per clock while
// the output is not stalled: an input register feeds a single pass of compare
// and counter logic whose result lands in the output register, which drives
// out_tvalid and holds it until out_tready takes it. Configuration writes
// on cfg_* are always ready and take effect the next cycle.
// depends on blpg_pkg, blpg_cfg_regs, blpg_core and assert_macros.svh
`include "assert_macros.svh"

module bicolor_led_pattern_generator_unit import blpg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [3:0] mode, [7:4] zero
  input  logic              in_tuser,   // [0] operation
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [0] green_on, [1] red_on, [7:2] zero
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  cfg_word_t         cfg_data
);

  cfg_t  cfg;
  logic  in_valid_r;
  item_t in_item_r;
  logic  out_valid_r;
  lvl_t  out_lvl_r;
  lvl_t  lvl;
  lvl_t  lvl_nxt;
  logic  advance;
  logic  proc;

  assign cfg_ready = 1'b1;

  blpg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // output register free or emptied this cycle
  assign advance   = !out_valid_r || out_tready;
  assign proc      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_item_r.op   <= op_t'(in_tuser);
      in_item_r.mode <= in_tdata[MODE_W-1:0];
    end
  end

  blpg_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (proc),
    .item       (in_item_r),
    .cfg        (cfg),
    .lvl        (lvl),
    .lvl_nxt    (lvl_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_lvl_r <= lvl_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_lvl_r.red, out_lvl_r.green};

  // a held input item keeps its payload while the output side is stalled
  `BLPG_ASSERT(a_in_hold, clk, rst_n,
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_item_r)))
  // both leds are never lit together
  `BLPG_NEVER(a_no_both_on, clk, rst_n, lvl.green && lvl.red)
  // a tick reports the levels as they stood
  `BLPG_ASSERT(a_tick_keeps, clk, rst_n,
    (proc && in_item_r.op == OP_TICK) |=> (out_lvl_r == $past(lvl)))
  // refresh to off darkens both leds
  `BLPG_ASSERT(a_off_dark, clk, rst_n,
    (proc && in_item_r.op == OP_REFRESH && in_item_r.mode == MODE_OFF)
      |=> (out_lvl_r == '0))

endmodule

// File: rtl/blpg_cfg_regs.sv
// configuration register file of the led pattern generator
// depends on blpg_pkg
module blpg_cfg_regs import blpg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [CFG_AW-1:0] wr_addr,
  input  cfg_word_t         wr_data,
  output cfg_t              cfg
);

  cfg_word_t slow_blink_r, fast_blink_r, fast_period_r;
  cfg_word_t fast_window_r, slow_period_r, slow_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_blink_r  <= RST_SLOW_BLINK;
      fast_blink_r  <= RST_FAST_BLINK;
      fast_period_r <= RST_FAST_PERIOD;
      fast_window_r <= RST_FAST_WINDOW;
      slow_period_r <= RST_SLOW_PERIOD;
      slow_window_r <= RST_SLOW_WINDOW;
    end else if (wr_en) begin
      unique case (wr_addr)
        REG_SLOW_BLINK:  slow_blink_r  <= wr_data;
        REG_FAST_BLINK:  fast_blink_r  <= wr_data;
        REG_FAST_PERIOD: fast_period_r <= wr_data;
        REG_FAST_WINDOW: fast_window_r <= wr_data;
        REG_SLOW_PERIOD: slow_period_r <= wr_data;
        REG_SLOW_WINDOW: slow_window_r <= wr_data;
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  assign cfg.slow_blink  = to_cnt(slow_blink_r);
  assign cfg.fast_blink  = to_cnt(fast_blink_r);
  assign cfg.fast_period = to_cnt(fast_period_r);
  assign cfg.fast_window = to_cnt(fast_window_r);
  assign cfg.slow_period = to_cnt(slow_period_r);
  assign cfg.slow_window = to_cnt(slow_window_r);

endmodule

// File: rtl/blpg_core.sv
// pattern state (counters, led levels, last mode) and its next-state logic
// depends on blpg_pkg
module blpg_core import blpg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  item_valid,
  input  item_t item,
  input  cfg_t  cfg,
  output lvl_t  lvl,
  output lvl_t  lvl_nxt
);

  cnt_t              blink_cnt_r, blink_cnt_nxt;
  cnt_t              strobe_cnt_r, strobe_cnt_nxt;
  lvl_t              lvl_r;
  logic [MODE_W-1:0] last_mode_r, last_mode_nxt;

  always_comb begin
    cnt_t half;
    cnt_t period;
    cnt_t window;
    logic use_red;
    logic do_blink;
    logic do_strobe;

    blink_cnt_nxt  = blink_cnt_r;
    strobe_cnt_nxt = strobe_cnt_r;
    lvl_nxt        = lvl_r;
    last_mode_nxt  = last_mode_r;
    half           = '0;
    period         = '0;
    window         = '0;
    use_red        = 1'b0;
    do_blink       = 1'b0;
    do_strobe      = 1'b0;

    if (item.op == OP_TICK) begin
      if (blink_cnt_r != '0) blink_cnt_nxt = blink_cnt_r - cnt_t'(1);
      if (strobe_cnt_r != '0) strobe_cnt_nxt = strobe_cnt_r - cnt_t'(1);
    end else begin
      // mode change restarts both counters
      if (item.mode != last_mode_r) begin
        blink_cnt_nxt  = '0;
        strobe_cnt_nxt = '0;
        last_mode_nxt  = item.mode;
      end
      unique case (item.mode) inside
        MODE_GREEN: lvl_nxt = '{red: 1'b0, green: 1'b1};
        MODE_RED:   lvl_nxt = '{red: 1'b1, green: 1'b0};
        MODE_SLOW_BLINK_G, MODE_SLOW_BLINK_R: begin
          do_blink = 1'b1;
          half     = cfg.slow_blink;
          use_red  = (item.mode == MODE_SLOW_BLINK_R);
        end
        MODE_FAST_BLINK_G, MODE_FAST_BLINK_R: begin
          do_blink = 1'b1;
          half     = cfg.fast_blink;
          use_red  = (item.mode == MODE_FAST_BLINK_R);
        end
        MODE_FAST_STRB_G, MODE_FAST_STRB_R: begin
          do_strobe = 1'b1;
          period    = cfg.fast_period;
          window    = cfg.fast_window;
          half      = cfg.fast_blink;
          use_red   = (item.mode == MODE_FAST_STRB_R);
        end
        MODE_SLOW_STRB_G, MODE_SLOW_STRB_R: begin
          do_strobe = 1'b1;
          period    = cfg.slow_period;
          window    = cfg.slow_window;
          half      = cfg.slow_window;
          use_red   = (item.mode == MODE_SLOW_STRB_R);
        end
        default: lvl_nxt = '0; // off, including the unused codes
      endcase

      if (do_strobe) begin
        if (strobe_cnt_nxt == '0 || strobe_cnt_nxt >= period) strobe_cnt_nxt = period;
        if (strobe_cnt_nxt <= window) do_blink = 1'b1;
        else lvl_nxt = '0;
      end

      // toggle only when the half period has run out
      if (do_blink && blink_cnt_nxt == '0) begin
        blink_cnt_nxt = half;
        if (use_red) lvl_nxt = '{red: ~lvl_r.red, green: 1'b0};
        else lvl_nxt = '{red: 1'b0, green: ~lvl_r.green};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_cnt_r  <= '0;
      strobe_cnt_r <= '0;
      lvl_r        <= '0;
      last_mode_r  <= '0;
    end else if (item_valid) begin
      blink_cnt_r  <= blink_cnt_nxt;
      strobe_cnt_r <= strobe_cnt_nxt;
      lvl_r        <= lvl_nxt;
      last_mode_r  <= last_mode_nxt;
    end
  end

  assign lvl = lvl_r;

endmodule

// File: test/testbench.sv
// self-checking testbench for bicolor_led_pattern_generator_unit: a class tracks the
// expected led levels per item while plain tasks drive items and register writes
// depends on blpg_pkg and the rtl of the unit
`timescale 1ns / 1ps

module testbench;
  import blpg_pkg::*;

  localparam int NUM_REGS        = 6;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTED     = 100;
  localparam int RESET_CYCLES    = 7;

  // register setting used in each phase of the random part
  localparam int PH_RESET   = 0;
  localparam int PH_ZERO    = 1;
  localparam int PH_MAX     = 2;
  localparam int PH_EXTREME = 3;
  localparam int PH_WIDE    = NUM_PHASES - 1;

  class led_level_tracker;
    cnt_t              regs [NUM_REGS];
    cnt_t              blink_cnt;
    cnt_t              strobe_cnt;
    logic              green_lvl;
    logic              red_lvl;
    logic [MODE_W-1:0] last_mode;
    lvl_t              expected_levels [$];
    int                mismatches;
    int                checked;

    function new();
      regs[REG_SLOW_BLINK]  = RST_SLOW_BLINK;
      regs[REG_FAST_BLINK]  = RST_FAST_BLINK;
      regs[REG_FAST_PERIOD] = RST_FAST_PERIOD;
      regs[REG_FAST_WINDOW] = RST_FAST_WINDOW;
      regs[REG_SLOW_PERIOD] = RST_SLOW_PERIOD;
      regs[REG_SLOW_WINDOW] = RST_SLOW_WINDOW;
      blink_cnt  = '0;
      strobe_cnt = '0;
      green_lvl  = 1'b0;
      red_lvl    = 1'b0;
      last_mode  = MODE_OFF;
      mismatches = 0;
      checked    = 0;
    endfunction

    // unmapped indexes are dropped
    function void set_reg(logic [CFG_AW-1:0] idx, cfg_word_t value);
      if (idx < NUM_REGS) regs[idx] = cnt_t'(value);
    endfunction

    function void toggle(cnt_t half, bit use_red);
      if (blink_cnt == 0) begin
        blink_cnt = half;
        if (use_red) begin
          red_lvl   = ~red_lvl;
          green_lvl = 1'b0;
        end else begin
          green_lvl = ~green_lvl;
          red_lvl   = 1'b0;
        end
      end
    endfunction

    function void strobe(cnt_t period, cnt_t window, cnt_t half, bit use_red);
      if (strobe_cnt == 0 || strobe_cnt >= period) strobe_cnt = period;
      if (strobe_cnt <= window) begin
        toggle(half, use_red);
      end else begin
        green_lvl = 1'b0;
        red_lvl   = 1'b0;
      end
    endfunction

    function void apply_mode(logic [MODE_W-1:0] m);
      if (m != last_mode) begin
        blink_cnt  = '0;
        strobe_cnt = '0;
        last_mode  = m;
      end
      case (m)
        MODE_GREEN: begin
          green_lvl = 1'b1;
          red_lvl   = 1'b0;
        end
        MODE_RED: begin
          green_lvl = 1'b0;
          red_lvl   = 1'b1;
        end
        MODE_SLOW_BLINK_G: toggle(regs[REG_SLOW_BLINK], 1'b0);
        MODE_SLOW_BLINK_R: toggle(regs[REG_SLOW_BLINK], 1'b1);
        MODE_FAST_BLINK_G: toggle(regs[REG_FAST_BLINK], 1'b0);
        MODE_FAST_BLINK_R: toggle(regs[REG_FAST_BLINK], 1'b1);
        MODE_FAST_STRB_G:
          strobe(regs[REG_FAST_PERIOD], regs[REG_FAST_WINDOW], regs[REG_FAST_BLINK], 1'b0);
        MODE_FAST_STRB_R:
          strobe(regs[REG_FAST_PERIOD], regs[REG_FAST_WINDOW], regs[REG_FAST_BLINK], 1'b1);
        MODE_SLOW_STRB_G:
          strobe(regs[REG_SLOW_PERIOD], regs[REG_SLOW_WINDOW], regs[REG_SLOW_WINDOW], 1'b0);
        MODE_SLOW_STRB_R:
          strobe(regs[REG_SLOW_PERIOD], regs[REG_SLOW_WINDOW], regs[REG_SLOW_WINDOW], 1'b1);
        default: begin
          // off and every code above the named modes
          green_lvl = 1'b0;
          red_lvl   = 1'b0;
        end
      endcase
    endfunction

    function void note_item(op_t op, logic [MODE_W-1:0] m);
      lvl_t lv;
      if (op == OP_TICK) begin
        if (blink_cnt != 0) blink_cnt = blink_cnt - cnt_t'(1);
        if (strobe_cnt != 0) strobe_cnt = strobe_cnt - cnt_t'(1);
      end else begin
        apply_mode(m);
      end
      lv.green = green_lvl;
      lv.red   = red_lvl;
      expected_levels.push_back(lv);
    endfunction

    task report_mismatch(string what);
      // keep the log short when the block is badly broken
      if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_levels(logic green, logic red);
      lvl_t want;
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("result g=%b r=%b with no item pending", green, red));
      end else begin
        want = expected_levels.pop_front();
        checked++;
        if (green !== want.green)
          report_mismatch($sformatf("result %0d green_on %b, want %b", checked, green,
                                    want.green));
        if (red !== want.red)
          report_mismatch($sformatf("result %0d red_on %b, want %b", checked, red, want.red));
      end
    endtask
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;   // [3:0] mode, [7:4] zero
  logic              in_tuser   = 1'b0; // [0] operation
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;         // [0] green_on, [1] red_on, [7:2] zero
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  cfg_word_t         cfg_data   = '0;

  led_level_tracker sb;
  int items_sent;
  int settings_run;
  int burst_left;
  int idle_cycles;
  int rx_style;
  int rx_cycle;
  int rx_hold;

  bicolor_led_pattern_generator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: picks a stall style at random and drives out_tready from it
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0: out_tready <= 1'b1;
      1: out_tready <= (rx_cycle % 4 != 3);
      2: out_tready <= $urandom_range(0, 1);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          rx_hold = $urandom_range(1, 24);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // signals are stable at the falling edge, so this sees what the next rising edge takes
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_levels(out_tdata[0], out_tdata[1]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: nothing moved for %0d cycles", $realtime, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(op_t op, logic [MODE_W-1:0] m);
    bit took;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(8 - MODE_W){1'b0}}, m};
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    sb.note_item(op, m);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 30);
    end
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, cfg_word_t value);
    bit took;
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    sb.set_reg(idx, value);
  endtask

  // let every pending result come out, then give the pipeline time to empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_word_t setting_value(int phase);
    case (phase)
      PH_ZERO: return '0;
      PH_MAX:  return '1;
      PH_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return cfg_word_t'(1);
          2: return '1;
          default: return cfg_word_t'($urandom_range(2, 12));
        endcase
      end
      PH_WIDE: return cfg_word_t'($urandom);
      default: return cfg_word_t'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic load_setting(int phase);
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_AW'(i), setting_value(phase));
    // a write to an unmapped index must change nothing
    if (phase % 2 == 1)
      write_reg(CFG_AW'($urandom_range(NUM_REGS, 2 ** CFG_AW - 1)), cfg_word_t'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  task automatic run_ticks(int count);
    for (int i = 0; i < count; i++) send_item(OP_TICK, MODE_W'($urandom));
  endtask

  task automatic run_random(int count);
    int target;
    int reps;
    logic [MODE_W-1:0] m;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        // one mode refreshed again and again with ticks in between
        m = ($urandom_range(0, 4) != 0) ? MODE_W'($urandom_range(MODE_SLOW_BLINK_G,
                                                                 MODE_SLOW_STRB_R))
                                        : MODE_W'($urandom);
        reps = $urandom_range(2, 8);
        for (int r = 0; r < reps; r++) begin
          send_item(OP_REFRESH, m);
          run_ticks(($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 6));
        end
      end else begin
        reps = $urandom_range(1, 5);
        for (int r = 0; r < reps; r++) send_item(op_t'($urandom_range(0, 1)), MODE_W'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    items_sent   = 0;
    settings_run = 1;
    burst_left   = 0;
    idle_cycles  = 0;
    rx_style     = 0;
    rx_cycle     = 0;
    rx_hold      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every mode code once, ticks carrying junk, repeated refreshes
    for (int m = 0; m < 2 ** MODE_W; m++) send_item(OP_REFRESH, MODE_W'(m));
    send_item(OP_TICK, '1);
    send_item(OP_TICK, MODE_OFF);
    send_item(OP_REFRESH, MODE_GREEN);
    send_item(OP_REFRESH, MODE_FAST_BLINK_R);
    send_item(OP_REFRESH, MODE_FAST_BLINK_R);
    run_ticks(5);
    send_item(OP_REFRESH, MODE_FAST_BLINK_R);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != PH_RESET) load_setting(phase);
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    $display("run covered %0d items (ticks and refreshes of all 16 mode codes)", items_sent);
    $display("under %0d register settings incl. all-zero and all-ones, %0d results checked",
             settings_run, sb.checked);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/blpg_pkg.sv
rtl/blpg_cfg_regs.sv
rtl/blpg_core.sv
rtl/bicolor_led_pattern_generator_unit.sv
test/testbench.sv
